@@ sv/dtl_pkg.sv @@
// ----------------------------------------------------------------------------
// dtl_pkg
// Types and constants shared by the delimiter token lexer modules.
// ----------------------------------------------------------------------------
package dtl_pkg;

   localparam int NUM_DELIM_REGS = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_PERIOD = 8'd46;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_NINE   = 8'd57;

   typedef enum logic [2:0] {
      REG_DELIM_COUNT = 3'd0,
      REG_DELIM_A     = 3'd1,
      REG_DELIM_B     = 3'd2,
      REG_DELIM_C     = 3'd3,
      REG_DELIM_D     = 3'd4,
      REG_SKIP_MODE   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      SKIP_NONE  = 2'd0,
      SKIP_SPACE = 2'd1,
      SKIP_WHITE = 2'd2,
      SKIP_ALIAS = 2'd3
   } skip_mode_type;

   typedef struct packed {
      logic [2:0]                          delim_count;
      logic [NUM_DELIM_REGS-1:0][7:0]      delim;
      skip_mode_type                       skip_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_done;
      logic       stream_done;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } slot_type;

endpackage

@@ sv/dtl_lexer.sv @@
// ----------------------------------------------------------------------------
// dtl_lexer
// Token state and per-byte decision; yields up to two results per transfer.
// ----------------------------------------------------------------------------
module dtl_lexer #(
   parameter int MAX_DELIMITERS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        in_byte,
   input  logic              is_final,
   input  dtl_pkg::cfg_type  cfg,
   output dtl_pkg::slot_type slot0,
   output dtl_pkg::slot_type slot1
);

   localparam int LIMIT = (MAX_DELIMITERS < dtl_pkg::NUM_DELIM_REGS) ?
                          MAX_DELIMITERS : dtl_pkg::NUM_DELIM_REGS;
   localparam logic [2:0] LIMIT_VAL = 3'(LIMIT);

   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_starts_ff, held_starts_in;
   logic       token_open_ff, token_open_in;
   logic       first_digit_ff, first_digit_in;
   logic       period_seen_ff, period_seen_in;
   logic       ends_unless_ff, ends_unless_in;

   logic [7:0] c;
   logic       digit;
   logic       dl;
   logic       join_tok;
   logic       is_period;
   logic [2:0] count_eff;
   logic       held_drop;
   logic       cur_drop;

   function automatic logic droppable(input logic [7:0] b, input dtl_pkg::skip_mode_type m);
      logic r;
      r = 1'b0;
      case (m)
         dtl_pkg::SKIP_NONE:  r = 1'b0;
         dtl_pkg::SKIP_SPACE: r = (b == dtl_pkg::CHAR_SPACE);
         default:             r = (b == dtl_pkg::CHAR_SPACE) || (b == dtl_pkg::CHAR_LF) ||
                                  (b == dtl_pkg::CHAR_CR);
      endcase
      return r;
   endfunction

   always_comb begin
      c = (in_byte == dtl_pkg::CHAR_TAB) ? dtl_pkg::CHAR_SPACE : in_byte;
      digit = (c >= dtl_pkg::CHAR_ZERO) && (c <= dtl_pkg::CHAR_NINE);
      is_period = (c == dtl_pkg::CHAR_PERIOD);
      count_eff = (cfg.delim_count > LIMIT_VAL) ? LIMIT_VAL : cfg.delim_count;
      dl = 1'b0;
      for (int i = 0; i < LIMIT; i++) begin
         if ((3'(i) < count_eff) && (cfg.delim[i] == c)) begin
            dl = 1'b1;
         end
      end

      if (!held_valid_ff || !token_open_ff) begin
         join_tok = 1'b0;
      end else if (ends_unless_ff && !digit) begin
         join_tok = 1'b0;
      end else if (!dl) begin
         join_tok = 1'b1;
      end else begin
         join_tok = is_period && first_digit_ff && !period_seen_ff;
      end

      // held byte, now decided
      held_drop = held_starts_ff && !join_tok && droppable(held_byte_ff, cfg.skip_mode);
      slot0.valid = held_valid_ff && !held_drop;
      slot0.rsp.out_byte = held_byte_ff;
      slot0.rsp.byte_valid = 1'b1;
      slot0.rsp.token_done = !join_tok;
      slot0.rsp.stream_done = 1'b0;

      // final byte flushes at once
      cur_drop = !join_tok && droppable(c, cfg.skip_mode);
      slot1.valid = is_final;
      slot1.rsp.out_byte = cur_drop ? 8'd0 : c;
      slot1.rsp.byte_valid = !cur_drop;
      slot1.rsp.token_done = !cur_drop;
      slot1.rsp.stream_done = 1'b1;

      if (!join_tok) begin
         first_digit_in = digit;
         period_seen_in = is_period;
         token_open_in = dl ? is_period : 1'b1;
         ends_unless_in = dl && is_period;
      end else begin
         first_digit_in = first_digit_ff;
         period_seen_in = period_seen_ff || is_period;
         ends_unless_in = dl;
         token_open_in = 1'b1;
      end
      held_byte_in = c;
      held_valid_in = 1'b1;
      held_starts_in = !join_tok;

      if (is_final) begin
         held_byte_in = 8'd0;
         held_valid_in = 1'b0;
         held_starts_in = 1'b0;
         token_open_in = 1'b0;
         first_digit_in = 1'b0;
         period_seen_in = 1'b0;
         ends_unless_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff <= 8'd0;
         held_valid_ff <= 1'b0;
         held_starts_ff <= 1'b0;
         token_open_ff <= 1'b0;
         first_digit_ff <= 1'b0;
         period_seen_ff <= 1'b0;
         ends_unless_ff <= 1'b0;
      end else if (take) begin
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         held_starts_ff <= held_starts_in;
         token_open_ff <= token_open_in;
         first_digit_ff <= first_digit_in;
         period_seen_ff <= period_seen_in;
         ends_unless_ff <= ends_unless_in;
      end
   end

endmodule

@@ sv/dtl_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// dtl_rsp_queue
// Result queue; takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module dtl_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  dtl_pkg::slot_type push0,
   input  dtl_pkg::slot_type push1,
   input  logic              pop,
   output dtl_pkg::rsp_type  head,
   output logic              not_empty,
   output logic              room_for_two,
   output logic [$clog2(dtl_pkg::QUEUE_DEPTH):0] level
);

   localparam int PW = $clog2(dtl_pkg::QUEUE_DEPTH);
   localparam logic [PW:0] ROOM_MAX = (PW+1)'(dtl_pkg::QUEUE_DEPTH - 2);

   dtl_pkg::rsp_type mem_ff [dtl_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic [1:0]    push_n;
   logic          do_pop;
   dtl_pkg::rsp_type first;

   always_comb begin
      push_n = 2'(push0.valid) + 2'(push1.valid);
      first = push0.valid ? push0.rsp : push1.rsp;
      do_pop = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(do_pop);
      count_in = count_ff + (PW+1)'(push_n) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + PW'(1)] <= push1.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room_for_two = (count_ff <= ROOM_MAX);
   assign level = count_ff;

endmodule

@@ sv/delimiter_token_lexer.sv @@
// ----------------------------------------------------------------------------
// delimiter_token_lexer
// Streaming byte lexer that marks token ends with one byte of look-behind.
// ----------------------------------------------------------------------------
// req_ carries one text byte per transfer, req_tlast marking the last byte.
// rsp_ carries one output byte per transfer with its token-end flag; tlast
// marks the result of the final byte. csr_ writes a register by index.
// Each byte is reported when the following byte arrives; the final byte is
// reported together with the byte before it. Results of a transfer go into
// the push register at that edge and into a four-entry result queue on the
// next; rsp_tvalid is high whenever the queue holds a result.
// req_tready is high while the queue and the push register together hold
// at most two results, so two more always fit. A stalled receiver backs up
// into req_ and nothing is lost. Sustained rate, while rsp_tready stays
// high: one byte per cycle; a final byte that yields two results costs a
// stall since the queue drains one result per cycle.
// Reset empties the queue, clears the token state and loads the default
// registers (one delimiter, space; skip mode off).
// ----------------------------------------------------------------------------
module delimiter_token_lexer #(
   parameter int MAX_DELIMITERS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // is_final
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] token_done
   output logic       rsp_tlast,   // stream_done
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int QW = $clog2(dtl_pkg::QUEUE_DEPTH);

   dtl_pkg::cfg_type  cfg_ff, cfg_in;
   dtl_pkg::slot_type slot0;
   dtl_pkg::slot_type slot1;
   dtl_pkg::slot_type push0_ff;
   dtl_pkg::slot_type push1_ff;
   dtl_pkg::rsp_type  head;
   logic              not_empty;
   logic              room_for_two;
   logic              take;
   logic [QW:0]       level;
   logic [QW:0]       queued_n;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (dtl_pkg::reg_index_type'(csr_index))
            dtl_pkg::REG_DELIM_COUNT: cfg_in.delim_count = csr_data[2:0];
            dtl_pkg::REG_DELIM_A:     cfg_in.delim[0] = csr_data;
            dtl_pkg::REG_DELIM_B:     cfg_in.delim[1] = csr_data;
            dtl_pkg::REG_DELIM_C:     cfg_in.delim[2] = csr_data;
            dtl_pkg::REG_DELIM_D:     cfg_in.delim[3] = csr_data;
            dtl_pkg::REG_SKIP_MODE:   cfg_in.skip_mode = dtl_pkg::skip_mode_type'(csr_data[1:0]);
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_count <= 3'd1;
         cfg_ff.delim[0] <= dtl_pkg::CHAR_SPACE;
         cfg_ff.delim[1] <= dtl_pkg::CHAR_LF;
         cfg_ff.delim[2] <= dtl_pkg::CHAR_CR;
         cfg_ff.delim[3] <= 8'd0;
         cfg_ff.skip_mode <= dtl_pkg::SKIP_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // room for two in the queue, counting what sits in the push register
   assign queued_n = level + (QW+1)'(push0_ff.valid) + (QW+1)'(push1_ff.valid);
   assign req_tready = room_for_two && (queued_n <= (QW+1)'(dtl_pkg::QUEUE_DEPTH - 2));
   assign take = req_tvalid && req_tready;

   dtl_lexer #(
      .MAX_DELIMITERS(MAX_DELIMITERS)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .take(take),
      .in_byte(req_tdata),
      .is_final(req_tlast),
      .cfg(cfg_ff),
      .slot0(slot0),
      .slot1(slot1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         push0_ff.valid <= 1'b0;
         push1_ff.valid <= 1'b0;
      end else begin
         push0_ff.valid <= take && slot0.valid;
         push1_ff.valid <= take && slot1.valid;
      end
      push0_ff.rsp <= slot0.rsp;
      push1_ff.rsp <= slot1.rsp;
   end

   dtl_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push0(push0_ff),
      .push1(push1_ff),
      .pop(rsp_tready),
      .head(head),
      .not_empty(not_empty),
      .room_for_two(room_for_two),
      .level(level)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.token_done, head.byte_valid};
   assign rsp_tlast = head.stream_done;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= (QW+1)'(dtl_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_final_two: assert property (@(posedge clock) disable iff (reset)
      (take && req_tlast) |=> push1_ff.valid)
      else $error("final byte produced no flush result");

   a_valid_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid == (level != '0))
      else $error("rsp_tvalid disagrees with queue level");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (push0_ff.valid || push1_ff.valid) |-> $past(take))
      else $error("result pushed without a transfer");

endmodule

@@ test/tb_delimiter_token_lexer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delimiter_token_lexer
// Self-checking bench for the streaming delimiter token lexer.
// ----------------------------------------------------------------------------
// Text bytes go in on req_, the register set is loaded over csr_ between
// phases while nothing is in flight. A cycle-free lexer kept in the bench
// predicts every response transfer; a monitor compares each rsp_ transfer
// field by field against the oldest prediction. Directed cases cover tab
// folding, digit tokens taking a period, period tokens waiting for a digit,
// the skip modes, a dropped final token, a one-byte stream and register
// extremes; random text streams follow under varied settings with random
// back-pressure and sender gaps, then a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_delimiter_token_lexer;

   localparam int LEX_MAX_DELIMS = 4;
   localparam int STALL_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b1;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = 3'd0;
   logic [7:0] csr_data = 8'h00;

   delimiter_token_lexer #(.MAX_DELIMITERS(LEX_MAX_DELIMS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // bench copy of the lexer
   dtl_pkg::cfg_type lex_cfg;
   logic [7:0]       pend_byte;
   logic             pend_valid;
   logic             pend_first;
   logic             tok_open;
   logic             num_token;
   logic             has_period;
   logic             need_digit;

   dtl_pkg::rsp_type expected_bytes[$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               req_gap_pct = 0;
   int               rsp_stall_pct = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_lexer();
      pend_byte  = 8'h00;
      pend_valid = 1'b0;
      pend_first = 1'b0;
      tok_open   = 1'b0;
      num_token  = 1'b0;
      has_period = 1'b0;
      need_digit = 1'b0;
   endfunction

   function automatic logic hits_delimiter(input logic [7:0] c);
      int n;
      n = (lex_cfg.delim_count > LEX_MAX_DELIMS) ? LEX_MAX_DELIMS : lex_cfg.delim_count;
      if (n > dtl_pkg::NUM_DELIM_REGS) n = dtl_pkg::NUM_DELIM_REGS;
      for (int i = 0; i < n; i++) begin
         if (lex_cfg.delim[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic is_dropped_ws(input logic [7:0] c);
      if (lex_cfg.skip_mode == dtl_pkg::SKIP_NONE) return 1'b0;
      if (c == dtl_pkg::CHAR_SPACE) return 1'b1;
      return (lex_cfg.skip_mode >= dtl_pkg::SKIP_WHITE) &&
             (c == dtl_pkg::CHAR_LF || c == dtl_pkg::CHAR_CR);
   endfunction

   function automatic void queue_token_byte(input logic [7:0] b, input logic starts,
                                            input logic done, input logic fin);
      dtl_pkg::rsp_type r;
      r = '0;
      if (starts && done && is_dropped_ws(b)) begin
         if (!fin) return;
         r.stream_done = 1'b1;
      end else begin
         r.out_byte    = b;
         r.byte_valid  = 1'b1;
         r.token_done  = done;
         r.stream_done = fin;
      end
      expected_bytes.push_back(r);
   endfunction

   function automatic void lex_byte(input logic [7:0] raw, input logic fin);
      logic [7:0] c;
      logic       digit;
      logic       dl;
      logic       joins;
      c = (raw == dtl_pkg::CHAR_TAB) ? dtl_pkg::CHAR_SPACE : raw;
      digit = (c >= dtl_pkg::CHAR_ZERO) && (c <= dtl_pkg::CHAR_NINE);
      dl = hits_delimiter(c);
      if (!pend_valid || !tok_open) joins = 1'b0;
      else if (need_digit && !digit) joins = 1'b0;
      else if (!dl) joins = 1'b1;
      else joins = (c == dtl_pkg::CHAR_PERIOD) && num_token && !has_period;

      if (pend_valid) queue_token_byte(pend_byte, pend_first, !joins, 1'b0);

      if (!joins) begin
         num_token  = digit;
         has_period = (c == dtl_pkg::CHAR_PERIOD);
         tok_open   = dl ? (c == dtl_pkg::CHAR_PERIOD) : 1'b1;
         need_digit = dl && (c == dtl_pkg::CHAR_PERIOD);
      end else begin
         if (c == dtl_pkg::CHAR_PERIOD) has_period = 1'b1;
         need_digit = dl;
         tok_open   = 1'b1;
      end
      pend_byte  = c;
      pend_valid = 1'b1;
      pend_first = !joins;

      if (fin) begin
         queue_token_byte(c, pend_first, 1'b1, 1'b1);
         clear_lexer();
      end
   endfunction

   // response monitor
   always @(posedge clock) begin : check_rsp
      dtl_pkg::rsp_type got;
      dtl_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte    = rsp_tdata;
         got.byte_valid  = rsp_tuser[0];
         got.token_done  = rsp_tuser[1];
         got.stream_done = rsp_tlast;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: byte %h valid %b done %b stream_done %b",
                        got.out_byte, got.byte_valid, got.token_done, got.stream_done);
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h %b %b %b, got %h %b %b %b",
                           want.out_byte, want.byte_valid, want.token_done, want.stream_done,
                           got.out_byte, got.byte_valid, got.token_done, got.stream_done);
            end
         end
      end
   end

   // response back-pressure
   initial begin
      @(posedge clock);
      forever begin
         if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_delimiter_token_lexer NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      lex_byte(b, fin);
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit ends_stream);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], ends_stream && (i == s.len() - 1));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input dtl_pkg::reg_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dtl_pkg::REG_DELIM_COUNT: lex_cfg.delim_count = val[2:0];
         dtl_pkg::REG_DELIM_A:     lex_cfg.delim[0] = val;
         dtl_pkg::REG_DELIM_B:     lex_cfg.delim[1] = val;
         dtl_pkg::REG_DELIM_C:     lex_cfg.delim[2] = val;
         dtl_pkg::REG_DELIM_D:     lex_cfg.delim[3] = val;
         dtl_pkg::REG_SKIP_MODE:   lex_cfg.skip_mode = dtl_pkg::skip_mode_type'(val[1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [2:0] cnt, input logic [7:0] da,
                               input logic [7:0] db, input logic [7:0] dc,
                               input logic [7:0] dd, input dtl_pkg::skip_mode_type sm);
      write_reg(dtl_pkg::REG_DELIM_COUNT, {5'd0, cnt});
      write_reg(dtl_pkg::REG_DELIM_A, da);
      write_reg(dtl_pkg::REG_DELIM_B, db);
      write_reg(dtl_pkg::REG_DELIM_C, dc);
      write_reg(dtl_pkg::REG_DELIM_D, dd);
      write_reg(dtl_pkg::REG_SKIP_MODE, {6'd0, sm});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_delim();
      case ($urandom_range(0, 7))
         0: return dtl_pkg::CHAR_SPACE;
         1: return dtl_pkg::CHAR_PERIOD;
         2: return dtl_pkg::CHAR_LF;
         3: return dtl_pkg::CHAR_CR;
         4: return dtl_pkg::CHAR_TAB;
         5: return 8'h2c;
         6: return dtl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return dtl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      if (r < 42) return dtl_pkg::CHAR_PERIOD;
      if (r < 52) return lex_cfg.delim[$urandom_range(0, 3)];
      if (r < 66) begin
         case ($urandom_range(0, 3))
            0: return dtl_pkg::CHAR_SPACE;
            1: return dtl_pkg::CHAR_TAB;
            2: return dtl_pkg::CHAR_LF;
            default: return dtl_pkg::CHAR_CR;
         endcase
      end
      if (r < 80) return 8'h61 + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic run_random_text(input int n_items, input bit pause_midway);
      int left;
      int len;
      bit pause;
      left = n_items;
      pause = pause_midway;
      while (left > 0) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         // a stream cut short by the budget carries its state over
         for (int i = 0; i < len && left > 0; i++) begin
            send_byte(pick_text_byte(), i == len - 1);
            left--;
         end
         if (pause && left < n_items / 2) begin
            wait_idle();
            pause = 1'b0;
         end
      end
   endtask

   task automatic test_reset_defaults();
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      // only space delimits; tab folds into it
      send_text("a\tb ", 1'b1);
   endtask

   task automatic test_delimiter_rules();
      wait_idle();
      // a delimiter register holding tab never matches
      apply_config(3'd4, dtl_pkg::CHAR_SPACE, dtl_pkg::CHAR_PERIOD, dtl_pkg::CHAR_LF,
                   dtl_pkg::CHAR_TAB, dtl_pkg::SKIP_NONE);
      // digit token takes one period, second period splits, period then digit joins
      send_text("7.25.\t.9", 1'b0);
      send_byte(8'hff, 1'b1);
   endtask

   task automatic test_skip_modes();
      wait_idle();
      apply_config(3'd3, dtl_pkg::CHAR_PERIOD, dtl_pkg::CHAR_SPACE, dtl_pkg::CHAR_CR,
                   8'h00, dtl_pkg::SKIP_WHITE);
      send_byte(8'h00, 1'b0);
      // dropped space token, dropped newline token, lone periods, dropped final
      send_text(" \n.. ", 1'b1);
      wait_idle();
      // count above the limit and the alias skip mode
      apply_config(3'd7, 8'hff, 8'h00, dtl_pkg::CHAR_LF, dtl_pkg::CHAR_PERIOD,
                   dtl_pkg::SKIP_ALIAS);
      send_text("\n", 1'b1);
      send_byte(8'hff, 1'b0);
      send_text("x\r", 1'b1);
   endtask

   task automatic test_random_streams();
      for (int p = 0; p < 7; p++) begin
         wait_idle();
         if (p == 0) begin
            apply_config(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, dtl_pkg::SKIP_NONE);
         end else if (p == 1) begin
            apply_config(3'd7, 8'hff, dtl_pkg::CHAR_PERIOD, dtl_pkg::CHAR_SPACE, 8'h00,
                         dtl_pkg::SKIP_ALIAS);
         end else begin
            apply_config(($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                     : 3'($urandom_range(2, 4)),
                         $urandom_range(0, 1) ? dtl_pkg::CHAR_PERIOD : pick_delim(),
                         pick_delim(), pick_delim(), pick_delim(),
                         dtl_pkg::skip_mode_type'($urandom_range(0, 3)));
         end
         req_gap_pct   = (p == 2) ? 0 : $urandom_range(5, 40);
         rsp_stall_pct = (p == 2) ? 0 : $urandom_range(5, 40);
         run_random_text(170, p == 3);
      end
   endtask

   task automatic test_full_rate();
      wait_idle();
      apply_config(3'd4, dtl_pkg::CHAR_SPACE, dtl_pkg::CHAR_PERIOD, dtl_pkg::CHAR_LF,
                   dtl_pkg::CHAR_CR, dtl_pkg::SKIP_WHITE);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      run_random_text(200, 1'b0);
   endtask

   initial begin
      lex_cfg.delim_count = 3'd1;
      lex_cfg.delim[0] = dtl_pkg::CHAR_SPACE;
      lex_cfg.delim[1] = dtl_pkg::CHAR_LF;
      lex_cfg.delim[2] = dtl_pkg::CHAR_CR;
      lex_cfg.delim[3] = 8'h00;
      lex_cfg.skip_mode = dtl_pkg::SKIP_NONE;
      clear_lexer();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_delimiter_rules();
      test_skip_modes();
      test_random_streams();
      test_full_rate();

      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("tb_delimiter_token_lexer OK");
      end else begin
         $display("tb_delimiter_token_lexer NOT OK");
      end
      $finish;
   end

endmodule
